// File: rtl/stfa_pkg.sv
// Shared types and constants for the sector to task-file address block.
// No dependencies; every other file in rtl/ imports this package.
package stfa_pkg;

  localparam int SECTOR_SHIFT   = 9;
  localparam int SecWidth       = 32;
  localparam int LenWidth       = 18;
  localparam int RegWidth       = 8;
  localparam int HeadCntWidth   = 5;
  localparam int CfgIdxWidth    = 8;
  localparam int StepsPerStage  = 4;
  localparam int StagesPerDiv   = SecWidth / StepsPerStage;
  localparam int NumStages      = 2 * StagesPerDiv;
  localparam int InDataWidth    = ((SecWidth + LenWidth + 7) / 8) * 8;
  localparam int OutFieldsWidth = 1 + 5 * RegWidth;
  localparam int OutDataWidth   = ((OutFieldsWidth + 7) / 8) * 8;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_LBA_MODE    = 8'd0,
    CFG_SPT         = 8'd1,
    CFG_HEAD_COUNT  = 8'd2,
    CFG_SELECT_BASE = 8'd3
  } cfg_idx_e;

  // Effective configuration, divisors already forced to at least one.
  typedef struct packed {
    logic                lba_mode;
    logic [RegWidth-1:0] spt;
    logic [RegWidth-1:0] hc;
    logic [RegWidth-1:0] select_base;
  } cfg_t;

  // Running state of the restoring divider.
  typedef struct packed {
    logic [SecWidth-1:0] quo;
    logic [RegWidth-1:0] rem;
  } div_state_t;

  // Payload that rides alongside the divider.
  typedef struct packed {
    logic                err;
    logic [RegWidth-1:0] count;
    logic [SecWidth-1:0] sec;
    logic [RegWidth-1:0] sec_rem;
  } side_t;

endpackage

// File: rtl/stfa_cfg.sv
// Configuration register file for the sector to task-file address block.
// Depends on stfa_pkg.
module stfa_cfg import stfa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [RegWidth-1:0]    cfg_data_i,
  output cfg_t                   cfg_o
);

  logic                    lba_mode_q;
  logic [RegWidth-1:0]     spt_q;
  logic [HeadCntWidth-1:0] hc_q;
  logic [RegWidth-1:0]     select_base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lba_mode_q    <= 1'b0;
      spt_q         <= 8'd63;
      hc_q          <= 5'd16;
      select_base_q <= 8'd160;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LBA_MODE:    lba_mode_q    <= cfg_data_i[0];
        CFG_SPT:         spt_q         <= cfg_data_i;
        CFG_HEAD_COUNT:  hc_q          <= cfg_data_i[HeadCntWidth-1:0];
        CFG_SELECT_BASE: select_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero divisors act as one
  always_comb begin
    cfg_o.lba_mode    = lba_mode_q;
    cfg_o.spt         = (spt_q == '0) ? RegWidth'(1) : spt_q;
    cfg_o.hc          = (hc_q == '0) ? RegWidth'(1) : RegWidth'(hc_q);
    cfg_o.select_base = select_base_q;
  end

endmodule

// File: rtl/stfa_div_stage.sv
// One pipeline stage of the restoring divider: retires StepsPerStage
// quotient bits per cycle while en_i is high. Depends on stfa_pkg.
module stfa_div_stage import stfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [RegWidth-1:0] divisor_i,
  input  div_state_t          st_i,
  output logic                valid_o,
  output div_state_t          st_o
);

  logic       valid_q;
  div_state_t st_q, st_d;

  always_comb begin
    logic [SecWidth-1:0] q;
    logic [RegWidth-1:0] r;
    logic [RegWidth:0]   ext;
    q = st_i.quo;
    r = st_i.rem;
    for (int k = 0; k < StepsPerStage; k++) begin
      ext = {r, q[SecWidth-1]};
      q   = {q[SecWidth-2:0], 1'b0};
      if (ext >= {1'b0, divisor_i}) begin
        ext  = ext - {1'b0, divisor_i};
        q[0] = 1'b1;
      end
      r = ext[RegWidth-1:0];
    end
    st_d.quo = q;
    st_d.rem = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

// File: rtl/sector_to_taskfile_address.sv
// Top level of the sector to task-file address translator.
// Depends on stfa_pkg, stfa_cfg and stfa_div_stage.
//
// Turns a linear sector number and a byte length into the five ATA
// task-file bytes plus a length error flag. One transaction is accepted
// every cycle while the output is not stalled, and each gives exactly one
// result, formed as it passes through two pipelined restoring
// dividers in series, 8 stages each at 4 quotient bits per stage: the
// first splits the sector number by sectors per track (remainder is the
// sector index, quotient the track), the second splits the track by the
// head count (remainder is the head, quotient the cylinder); one more
// register forms the output bytes. In LBA mode the dividers still run but
// their results are ignored. A length that is not a multiple of 512 gives
// length_error with all other fields zero. Zero sectors per track or zero
// head count divide by one. The whole pipeline advances together whenever
// the output register is empty or being drained, so a stall on the master
// side holds every stage in place. Configuration must only be written
// while no transaction is in flight; the config channel is always ready.
module sector_to_taskfile_address import stfa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // slave side
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [31:0] sector_number, [49:32] byte_length, rest zero
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // master side
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [0] length_error, [8:1] count_reg, [16:9] sector_reg,
  // [24:17] cyl_low_reg, [32:25] cyl_high_reg, [40:33] select_reg, rest zero
  output logic [OutDataWidth-1:0] m_axis_tdata,
  // configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [RegWidth-1:0]     cfg_data_i
);

  cfg_t cfg;

  stfa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // global advance: output slot free or being taken
  logic out_valid_q;
  logic adv;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  logic [SecWidth-1:0] in_sec;
  logic [LenWidth-1:0] in_len;
  side_t               in_side;
  assign in_sec = s_axis_tdata[SecWidth-1:0];
  assign in_len = s_axis_tdata[SecWidth+LenWidth-1:SecWidth];

  always_comb begin
    in_side.err     = |in_len[SECTOR_SHIFT-1:0];
    in_side.count   = RegWidth'(in_len >> SECTOR_SHIFT);
    in_side.sec     = in_sec;
    in_side.sec_rem = '0;
  end

  logic       stg_valid [NumStages];
  div_state_t stg_st    [NumStages];
  side_t      side_q    [NumStages];

  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    logic                valid_in;
    div_state_t          st_in;
    logic [RegWidth-1:0] divisor;

    if (i == 0) begin : g_first
      assign valid_in  = s_axis_tvalid;
      assign st_in.quo = in_sec;
      assign st_in.rem = '0;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          side_q[i] <= in_side;
        end
      end
    end else if (i == StagesPerDiv) begin : g_handoff
      // track enters the second divider, sector index moves to the side
      side_t side_d;
      assign valid_in  = stg_valid[i-1];
      assign st_in.quo = stg_st[i-1].quo;
      assign st_in.rem = '0;
      always_comb begin
        side_d         = side_q[i-1];
        side_d.sec_rem = stg_st[i-1].rem;
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          side_q[i] <= side_d;
        end
      end
    end else begin : g_mid
      assign valid_in = stg_valid[i-1];
      assign st_in    = stg_st[i-1];
      always_ff @(posedge clk_i) begin
        if (adv) begin
          side_q[i] <= side_q[i-1];
        end
      end
    end

    assign divisor = (i < StagesPerDiv) ? cfg.spt : cfg.hc;

    stfa_div_stage u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .valid_i   (valid_in),
      .divisor_i (divisor),
      .st_i      (st_in),
      .valid_o   (stg_valid[i]),
      .st_o      (stg_st[i])
    );
  end

  // output byte formation
  side_t               last_side;
  div_state_t          last_st;
  logic [RegWidth-1:0] sector_b, cyl_lo_b, cyl_hi_b, head_b, count_b, select_b;
  logic                err_b;
  logic [OutDataWidth-1:0] out_d, out_q;

  assign last_side = side_q[NumStages-1];
  assign last_st   = stg_st[NumStages-1];

  always_comb begin
    if (cfg.lba_mode) begin
      sector_b = last_side.sec[7:0];
      cyl_lo_b = last_side.sec[15:8];
      cyl_hi_b = last_side.sec[23:16];
      head_b   = {4'b0, last_side.sec[27:24]};
    end else begin
      sector_b = last_side.sec_rem + RegWidth'(1);
      cyl_lo_b = last_st.quo[7:0];
      cyl_hi_b = last_st.quo[15:8];
      head_b   = last_st.rem;
    end
    select_b = head_b | cfg.select_base;
    count_b  = last_side.count;
    err_b    = last_side.err;
    if (err_b) begin
      sector_b = '0;
      cyl_lo_b = '0;
      cyl_hi_b = '0;
      select_b = '0;
      count_b  = '0;
    end
    out_d = '0;
    out_d[OutFieldsWidth-1:0] = {select_b, cyl_hi_b, cyl_lo_b, sector_b, count_b, err_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= stg_valid[NumStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for sector_to_taskfile_address (LBA / CHS task-file translation).
// Depends on rtl/stfa_pkg.sv and rtl/sector_to_taskfile_address.sv; reads no files.
module tb_top import stfa_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 30;  // comfortably above the pipeline depth
  localparam int RandPerPhase = 85;
  localparam int NumPhases = 8;

  // one request: linear sector plus byte length
  typedef struct {
    logic [SecWidth-1:0] sector;
    logic [LenWidth-1:0] len;
  } xfer_req_t;

  // task-file bytes of one result
  typedef struct {
    logic                err;
    logic [RegWidth-1:0] count;
    logic [RegWidth-1:0] sec;
    logic [RegWidth-1:0] cyl_lo;
    logic [RegWidth-1:0] cyl_hi;
    logic [RegWidth-1:0] sel;
  } taskfile_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i = '0;
  logic [RegWidth-1:0]     cfg_data_i = '0;

  // testbench copy of the geometry registers, at their reset values
  logic                    geo_lba = 1'b0;
  logic [RegWidth-1:0]     geo_spt = 8'd63;
  logic [HeadCntWidth-1:0] geo_heads = 5'd16;
  logic [RegWidth-1:0]     geo_select_base = 8'd160;

  xfer_req_t req_q[$];        // requests waiting for the driver
  xfer_req_t req_on_bus;      // request currently presented on the slave side
  taskfile_t taskfile_q[$];   // predicted task-file bytes, oldest first
  logic      req_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  sector_to_taskfile_address uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predict the task-file bytes for one request under the current geometry.
  function automatic taskfile_t translate_address(xfer_req_t r);
    taskfile_t t;
    logic [SecWidth-1:0] spt;
    logic [SecWidth-1:0] heads;
    logic [SecWidth-1:0] track;
    logic [SecWidth-1:0] cyl;
    logic [SecWidth-1:0] head;
    t = '{default: '0};
    // misaligned length: flag only, every byte zero
    if (r.len[SECTOR_SHIFT-1:0] != '0) begin
      t.err = 1'b1;
      return t;
    end
    t.count = RegWidth'(r.len >> SECTOR_SHIFT);
    if (geo_lba) begin
      t.sec    = r.sector[7:0];
      t.cyl_lo = r.sector[15:8];
      t.cyl_hi = r.sector[23:16];
      head     = SecWidth'(r.sector[27:24]);
    end else begin
      // zero divisors count as one
      spt      = (geo_spt == '0) ? 1 : SecWidth'(geo_spt);
      heads    = (geo_heads == '0) ? 1 : SecWidth'(geo_heads);
      track    = r.sector / spt;
      cyl      = track / heads;
      t.sec    = RegWidth'(r.sector % spt + 1);
      head     = track % heads;  // may exceed 15 with more than 16 heads
      t.cyl_lo = cyl[7:0];
      t.cyl_hi = cyl[15:8];
    end
    t.sel = RegWidth'(head | SecWidth'(geo_select_base));
    return t;
  endfunction

  function automatic xfer_req_t random_request();
    xfer_req_t r;
    case ($urandom_range(3))
      0:       r.sector = $urandom();
      1:       r.sector = $urandom_range(0, 65535);
      2:       r.sector = $urandom_range(0, 4000000);
      default: r.sector = {4'($urandom_range(0, 15)), 28'($urandom())};
    endcase
    // mostly whole sectors, some up to the full 18-bit range, some misaligned
    if ($urandom_range(4) == 0) r.len = LenWidth'($urandom());
    else if ($urandom_range(5) == 0) r.len = {9'($urandom_range(0, 511)), 9'd0};
    else r.len = LenWidth'($urandom_range(0, 256) << SECTOR_SHIFT);
    return r;
  endfunction

  // Field extremes, track and cylinder boundaries, misaligned lengths.
  task automatic push_directed();
    req_q.push_back('{sector: 32'd0,          len: 18'd0});
    req_q.push_back('{sector: 32'hFFFF_FFFF,  len: 18'h20000});
    req_q.push_back('{sector: 32'h0FFF_FFFF,  len: 18'h3FE00});
    req_q.push_back('{sector: 32'hF000_0000,  len: 18'd512});
    req_q.push_back('{sector: 32'd62,         len: 18'd512});
    req_q.push_back('{sector: 32'd63,         len: 18'd1024});
    req_q.push_back('{sector: 32'd1007,       len: 18'd512});
    req_q.push_back('{sector: 32'd1008,       len: 18'd512});
    req_q.push_back('{sector: 32'h00FF_FFFF,  len: 18'h3FFFF});
    req_q.push_back('{sector: 32'd5,          len: 18'd1});
    req_q.push_back('{sector: 32'd5,          len: 18'd511});
    req_q.push_back('{sector: 32'h1234_5678,  len: 18'h00200});
  endtask

  // Present one register write; valid stays high for back-to-back writes.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [RegWidth-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic check_field(input string name, input logic [RegWidth-1:0] want,
                             input logic [RegWidth-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Driver: new transaction or idle cycle at each falling edge, once the
  // previous one was taken. The master-side ready is redrawn every cycle.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_on_bus = req_q.pop_front();
        s_axis_tdata  <= InDataWidth'({req_on_bus.len, req_on_bus.sector});
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: tracks config writes, predicts at acceptance, checks results.
  always @(posedge clk_i) begin
    taskfile_t got;
    taskfile_t want;
    cycle_count <= cycle_count + 1;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid_i && cfg_ready_o) begin
        // bits above a register's width are dropped, unknown indexes ignored
        case (cfg_idx_e'(cfg_index_i))
          CFG_LBA_MODE:    geo_lba <= cfg_data_i[0];
          CFG_SPT:         geo_spt <= cfg_data_i;
          CFG_HEAD_COUNT:  geo_heads <= cfg_data_i[HeadCntWidth-1:0];
          CFG_SELECT_BASE: geo_select_base <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) taskfile_q.push_back(translate_address(req_on_bus));
      if (m_axis_tvalid && m_axis_tready) begin
        got.err    = m_axis_tdata[0];
        got.count  = m_axis_tdata[8:1];
        got.sec    = m_axis_tdata[16:9];
        got.cyl_lo = m_axis_tdata[24:17];
        got.cyl_hi = m_axis_tdata[32:25];
        got.sel    = m_axis_tdata[40:33];
        if (taskfile_q.size() == 0) begin
          $error("result transaction with no request outstanding: 0x%0h", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = taskfile_q.pop_front();
          check_field("length_error", RegWidth'(want.err), RegWidth'(got.err));
          check_field("count_reg", want.count, got.count);
          check_field("sector_reg", want.sec, got.sec);
          check_field("cyl_low_reg", want.cyl_lo, got.cyl_lo);
          check_field("cyl_high_reg", want.cyl_hi, got.cyl_hi);
          check_field("select_reg", want.sel, got.sel);
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("sector_to_taskfile_address test failed");
      $finish;
    end
  end

  // Stimulus: eight phases, each setting a geometry and an idling pattern.
  // Geometry is only rewritten once the pipeline has drained.
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < NumPhases; phase++) begin
      while (req_q.size() != 0 || s_axis_tvalid || taskfile_q.size() != 0) @(negedge clk_i);
      repeat (DrainCycles) @(negedge clk_i);

      case (phase)
        0: ;  // reset geometry: CHS, 63 sectors, 16 heads, select 0xA0
        1: begin  // LBA with the usual LBA select byte
          write_reg(CFG_LBA_MODE, 8'd1);
          write_reg(CFG_SELECT_BASE, 8'hE0);
        end
        2: begin  // smallest geometry, empty select base
          write_reg(CFG_LBA_MODE, 8'd0);
          write_reg(CFG_SPT, 8'd1);
          write_reg(CFG_HEAD_COUNT, 8'd1);
          write_reg(CFG_SELECT_BASE, 8'h00);
        end
        3: begin  // zero divisors; writes to unknown indexes must not land
          write_reg(CFG_SPT, 8'd0);
          write_reg(CFG_HEAD_COUNT, 8'd0);
          write_reg(CFG_SELECT_BASE, 8'hFF);
          write_reg(8'd4, 8'd1);
          write_reg(8'd255, 8'd7);
        end
        4: begin  // largest geometry; head count truncates to 31, lba bit to 0
          write_reg(CFG_LBA_MODE, 8'hFE);
          write_reg(CFG_SPT, 8'd255);
          write_reg(CFG_HEAD_COUNT, 8'hFF);
          write_reg(CFG_SELECT_BASE, 8'hA0);
        end
        5: begin  // LBA with a clear select base; stray bits above bit 0
          write_reg(CFG_LBA_MODE, 8'h03);
          write_reg(CFG_SELECT_BASE, 8'h00);
        end
        default: begin  // random legal drive geometry
          write_reg(CFG_LBA_MODE, 8'd0);
          write_reg(CFG_SPT, 8'($urandom_range(1, 255)));
          write_reg(CFG_HEAD_COUNT, 8'($urandom_range(1, 16)));
          write_reg(CFG_SELECT_BASE, 8'($urandom()));
        end
      endcase
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase

      if (phase < 2) push_directed();
      for (int n = 0; n < RandPerPhase; n++) req_q.push_back(random_request());
    end

    while (req_q.size() != 0 || s_axis_tvalid || taskfile_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (taskfile_q.size() != 0) begin
      $error("%0d predicted results never arrived", taskfile_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("sector_to_taskfile_address test passed");
    end else begin
      $display("sector_to_taskfile_address test failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/stfa_pkg.sv
rtl/stfa_cfg.sv
rtl/stfa_div_stage.sv
rtl/sector_to_taskfile_address.sv
verif/tb_top.sv
